>>> design/aip_pkg.sv
// ----------------------------------------------------------------------------
// aip_pkg
// Types, codes and constants shared by the ascii integer parser modules.
// ----------------------------------------------------------------------------
package aip_pkg;

  // result type codes
  localparam logic [2:0] TYPE_U16 = 3'd0;
  localparam logic [2:0] TYPE_I16 = 3'd1;
  localparam logic [2:0] TYPE_U32 = 3'd2;
  localparam logic [2:0] TYPE_I32 = 3'd3;
  localparam logic [2:0] TYPE_U64 = 3'd4;
  localparam logic [2:0] TYPE_I64 = 3'd5;

  localparam logic [63:0] DEC_LIMIT = 64'd1844674407370955161;

  // character queue between classifier and parser
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [3:0] {
    CLS_NONE,
    CLS_WS,
    CLS_DIGIT,
    CLS_HEXALPHA,
    CLS_X,
    CLS_UNDER,
    CLS_PLUS,
    CLS_MINUS,
    CLS_OTHER
  } cls_t;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_SIGN,
    PH_ZERO,
    PH_DEC,
    PH_HEX,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    cls_t       cls;
    logic [3:0] nib;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [63:0] mag;
    logic        negative;
    logic        failed;
    logic        empty;
  } fin_t;

  function automatic logic is_signed_type(input logic [2:0] t);
    return (t == TYPE_I16) || (t == TYPE_I32) || (t == TYPE_I64);
  endfunction

endpackage

>>> design/aip_front.sv
// ----------------------------------------------------------------------------
// aip_front
// Accepts characters and classifies them for the parser queue.
// ----------------------------------------------------------------------------
module aip_front import aip_pkg::*; (
  input  logic       push,
  output logic       full,
  input  logic [7:0] ch,
  input  logic       last,
  input  logic       q_full,
  output logic       q_push,
  output item_t      q_item
);

  cls_t       cls;
  logic [3:0] nib;

  always_comb begin
    nib = 4'd0;
    unique case (ch) inside
      8'd0: cls = CLS_NONE;
      8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd32: cls = CLS_WS;
      [8'd48:8'd57]: begin
        cls = CLS_DIGIT;
        nib = 4'(ch - 8'd48);
      end
      [8'd97:8'd102]: begin
        cls = CLS_HEXALPHA;
        nib = 4'(ch - 8'd87);
      end
      [8'd65:8'd70]: begin
        cls = CLS_HEXALPHA;
        nib = 4'(ch - 8'd55);
      end
      8'd120: cls = CLS_X;
      8'd95:  cls = CLS_UNDER;
      8'd43:  cls = CLS_PLUS;
      8'd45:  cls = CLS_MINUS;
      default: cls = CLS_OTHER;
    endcase
  end

  assign full   = q_full;
  assign q_push = push & ~q_full;
  assign q_item = '{cls: cls, nib: nib, last: last};

endmodule

>>> design/aip_queue.sv
// ----------------------------------------------------------------------------
// aip_queue
// Small queue of classified characters between classifier and parser.
// ----------------------------------------------------------------------------
module aip_queue import aip_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr_en,
  input  item_t wr_item,
  output logic  full,
  input  logic  rd_en,
  output item_t rd_item,
  output logic  empty
);

  item_t            mem [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     count;

  assign full    = (count == (QAW+1)'(QDEPTH));
  assign empty   = (count == '0);
  assign rd_item = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> design/aip_parse.sv
// ----------------------------------------------------------------------------
// aip_parse
// Walks each queued string one classified character per cycle and builds
// the magnitude; hands the finished string to the result stage when ready.
// ----------------------------------------------------------------------------
module aip_parse import aip_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [2:0] result_type,
  input  item_t      item,
  input  logic       item_valid,
  output logic       item_pop,
  input  logic       fin_ready,
  output logic       fin_load,
  output fin_t       fin_data
);

  phase_t      phase, phase_next;
  logic [63:0] acc, acc_next;
  logic        negative, negative_next;
  logic        failed, failed_next;

  logic [63:0] dec_sum;
  logic        dec_ovf;
  logic        is_ws;
  logic        is_dig;
  logic        is_hex;
  logic        take;

  // acc * 10 + digit as two shifts and two adds
  assign dec_sum = {acc[60:0], 3'b000} + {acc[62:0], 1'b0} + {60'd0, item.nib};
  assign dec_ovf = (acc > DEC_LIMIT) || ((acc == DEC_LIMIT) && (item.nib > 4'd5));

  assign is_ws  = (item.cls == CLS_WS);
  assign is_dig = (item.cls == CLS_DIGIT);
  assign is_hex = is_dig || (item.cls == CLS_HEXALPHA);

  // only the final character of a string waits for the result stage
  assign item_pop = item_valid && (!item.last || fin_ready);
  assign fin_load = item_pop && item.last;
  assign take     = item_pop && (item.cls != CLS_NONE) && !failed;

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    negative_next = negative;
    failed_next   = failed;
    if (take) begin
      unique case (phase)
        PH_LEAD, PH_SIGN: begin
          if (is_ws) begin
            phase_next = phase;
          end else if ((phase == PH_LEAD) && is_signed_type(result_type) &&
                       ((item.cls == CLS_PLUS) || (item.cls == CLS_MINUS))) begin
            negative_next = (item.cls == CLS_MINUS);
            phase_next    = PH_SIGN;
          end else if (is_dig) begin
            acc_next   = {60'd0, item.nib};
            phase_next = (item.nib == 4'd0) ? PH_ZERO : PH_DEC;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_ZERO, PH_DEC: begin
          if ((phase == PH_ZERO) && (item.cls == CLS_X)) begin
            phase_next = PH_HEX;
          end else if (is_dig) begin
            if (dec_ovf) begin
              failed_next = 1'b1;
            end else begin
              acc_next   = dec_sum;
              phase_next = PH_DEC;
            end
          end else if (is_ws) begin
            phase_next = PH_TAIL;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_HEX: begin
          if (is_hex) begin
            if (acc[63:60] != 4'd0) begin
              failed_next = 1'b1;
            end else begin
              acc_next = {acc[59:0], item.nib};
            end
          end else if (item.cls == CLS_UNDER) begin
            phase_next = phase;
          end else if (is_ws) begin
            phase_next = PH_TAIL;
          end else begin
            failed_next = 1'b1;
          end
        end
        PH_TAIL: begin
          if (!is_ws) begin
            failed_next = 1'b1;
          end
        end
        default: begin
          failed_next = 1'b1;
        end
      endcase
    end

    fin_data = '{mag:      acc_next,
                 negative: negative_next,
                 failed:   failed_next,
                 empty:    (phase_next == PH_LEAD) || (phase_next == PH_SIGN)};

    // string done: start the next one from scratch
    if (fin_load) begin
      phase_next    = PH_LEAD;
      acc_next      = '0;
      negative_next = 1'b0;
      failed_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LEAD;
      acc      <= '0;
      negative <= 1'b0;
      failed   <= 1'b0;
    end else begin
      phase    <= phase_next;
      acc      <= acc_next;
      negative <= negative_next;
      failed   <= failed_next;
    end
  end

endmodule

>>> design/aip_finish.sv
// ----------------------------------------------------------------------------
// aip_finish
// Range check and sign application for a finished string, followed by a
// two-entry result queue.
// ----------------------------------------------------------------------------
module aip_finish import aip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [2:0]  result_type,
  input  logic        fin_load,
  input  fin_t        fin_data,
  output logic        fin_ready,
  input  logic        pop,
  output logic        empty,
  output logic [63:0] value,
  output logic        parse_error
);

  fin_t        fin;
  logic        fin_valid;
  logic        res_push;
  logic        over_pos;
  logic        over_neg;
  logic        res_err;
  logic [63:0] res_val;
  logic [63:0] m;

  logic [63:0] oq_val [2];
  logic        oq_err [2];
  logic        oq_wr;
  logic        oq_rd;
  logic [1:0]  oq_count;
  logic        oq_full;

  assign m = fin.mag;

  // magnitude above the positive limit / above limit plus one
  always_comb begin
    over_pos = 1'b0;
    over_neg = 1'b0;
    unique case (result_type)
      TYPE_U16: over_pos = |m[63:16];
      TYPE_I16: begin
        over_pos = |m[63:15];
        over_neg = (|m[63:16]) || (m[15] && (|m[14:0]));
      end
      TYPE_U32: over_pos = |m[63:32];
      TYPE_I32: begin
        over_pos = |m[63:31];
        over_neg = (|m[63:32]) || (m[31] && (|m[30:0]));
      end
      TYPE_I64: begin
        over_pos = m[63];
        over_neg = m[63];
      end
      default: over_pos = 1'b0;
    endcase

    res_err = fin.failed || fin.empty;
    res_val = '0;
    if (!res_err) begin
      if (is_signed_type(result_type) && m[63]) begin
        res_err = 1'b1;
      end else if (is_signed_type(result_type) && fin.negative) begin
        res_err = over_neg;
        res_val = over_neg ? 64'd0 : (64'd0 - m);
      end else begin
        res_err = over_pos;
        res_val = over_pos ? 64'd0 : m;
      end
    end
  end

  assign oq_full   = (oq_count == 2'd2);
  assign res_push  = fin_valid && !oq_full;
  assign fin_ready = !fin_valid || !oq_full;

  always_ff @(posedge clk) begin
    if (fin_load) begin
      fin <= fin_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_load) begin
      fin_valid <= 1'b1;
    end else if (res_push) begin
      fin_valid <= 1'b0;
    end
  end

  // result queue
  assign empty       = (oq_count == 2'd0);
  assign value       = oq_val[oq_rd];
  assign parse_error = oq_err[oq_rd];

  always_ff @(posedge clk) begin
    if (res_push) begin
      oq_val[oq_wr] <= res_val;
      oq_err[oq_wr] <= res_err;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= 1'b0;
      oq_rd    <= 1'b0;
      oq_count <= 2'd0;
    end else begin
      if (res_push) begin
        oq_wr <= ~oq_wr;
      end
      if (pop && !empty) begin
        oq_rd <= ~oq_rd;
      end
      if (res_push && !(pop && !empty)) begin
        oq_count <= oq_count + 2'd1;
      end else if (!res_push && (pop && !empty)) begin
        oq_count <= oq_count - 2'd1;
      end
    end
  end

endmodule

>>> design/ascii_integer_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit
// Parses a decimal or 0x-hex character string, one character per request,
// into a u16/i16/u32/i32/u64/i64 value with an error flag.
// ----------------------------------------------------------------------------
// result path: the request carrying a string's last character goes into the
//   character queue, then the finish register, then the result queue
// throughput: one character per cycle while the character queue is not full;
//   a string's last character also waits until the result stage is ready
// reset: synchronous; queues empty, parser at leading whitespace,
//   result_type = u64
module ascii_integer_parser_unit import aip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] value,
  output logic        parse_error,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  logic [2:0] result_type;
  logic       q_full;
  logic       q_push;
  item_t      q_in;
  item_t      q_out;
  logic       q_empty;
  logic       q_pop;
  logic       fin_ready;
  logic       fin_load;
  fin_t       fin_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_type <= TYPE_U64;
    end else if (cfg_valid && cfg_ready) begin
      result_type <= cfg_data;
    end
  end

  aip_front u_front (
    .push   (push),
    .full   (full),
    .ch     (ch),
    .last   (last),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  aip_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_item (q_in),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_item (q_out),
    .empty   (q_empty)
  );

  aip_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .result_type (result_type),
    .item        (q_out),
    .item_valid  (!q_empty),
    .item_pop    (q_pop),
    .fin_ready   (fin_ready),
    .fin_load    (fin_load),
    .fin_data    (fin_data)
  );

  aip_finish u_finish (
    .clk         (clk),
    .rst         (rst),
    .result_type (result_type),
    .fin_load    (fin_load),
    .fin_data    (fin_data),
    .fin_ready   (fin_ready),
    .pop         (pop),
    .empty       (empty),
    .value       (value),
    .parse_error (parse_error)
  );

endmodule

>>> dv/ascii_integer_parser_checker.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_checker
// Watches the character and result queues of the parser, runs its own
// string parser on every accepted character and compares each popped result
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module ascii_integer_parser_checker import aip_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [7:0]  ch,
  input  logic        last,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] value,
  input  logic        parse_error,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  output int          fail_count,
  output int          results_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] I64_MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [63:0] value;
    logic        err;
  } parse_result_t;

  parse_result_t results_due[$];
  int            fails = 0;

  // parser state as the block should hold it
  phase_t      ph;
  logic [63:0] acc;
  logic        neg;
  logic        bad;
  logic [2:0]  rtype;

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic type_has_sign(input logic [2:0] t);
    return (t == TYPE_I16) || (t == TYPE_I32) || (t == TYPE_I64);
  endfunction

  task automatic clear_string();
    ph  = PH_LEAD;
    acc = '0;
    neg = 1'b0;
    bad = 1'b0;
  endtask

  task automatic start_number(input logic [7:0] c);
    if (c == "0") begin
      acc = '0;
      ph  = PH_ZERO;
    end else if (c >= "1" && c <= "9") begin
      acc = 64'(c - "0");
      ph  = PH_DEC;
    end else begin
      bad = 1'b1;
    end
  endtask

  task automatic add_digit(input logic [3:0] d);
    // exact 64-bit overflow test before the multiply by ten
    if (acc > DEC_LIMIT || (acc == DEC_LIMIT && d > 4'd5)) begin
      bad = 1'b1;
    end else begin
      acc = acc * 64'd10 + 64'(d);
      ph  = PH_DEC;
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    logic       digit;
    logic       hex_digit;
    logic [3:0] nib;
    digit     = (c >= "0" && c <= "9");
    hex_digit = 1'b1;
    nib       = '0;
    case (ph)
      PH_LEAD: begin
        if (!is_space(c)) begin
          if (type_has_sign(rtype) && (c == "+" || c == "-")) begin
            neg = (c == "-");
            ph  = PH_SIGN;
          end else begin
            start_number(c);
          end
        end
      end
      PH_SIGN: begin
        if (!is_space(c)) start_number(c);
      end
      PH_ZERO, PH_DEC: begin
        if (ph == PH_ZERO && c == "x") ph = PH_HEX;
        else if (digit) add_digit(4'(c - "0"));
        else if (is_space(c)) ph = PH_TAIL;
        else bad = 1'b1;
      end
      PH_HEX: begin
        if (digit) nib = 4'(c - "0");
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
        else hex_digit = 1'b0;
        if (hex_digit) begin
          if (acc[63:60] != 4'd0) bad = 1'b1;
          else acc = {acc[59:0], nib};
        end else if (c == "_") begin
          // digit separator
        end else if (is_space(c)) begin
          ph = PH_TAIL;
        end else begin
          bad = 1'b1;
        end
      end
      default: begin
        if (!is_space(c)) bad = 1'b1;
      end
    endcase
  endtask

  function automatic parse_result_t finish_string();
    logic [63:0]   top_mag;
    parse_result_t r;
    r.value = '0;
    r.err   = 1'b1;
    if (bad || ph == PH_LEAD || ph == PH_SIGN) return r;
    case (rtype)
      TYPE_U16: top_mag = 64'hFFFF;
      TYPE_I16: top_mag = 64'h7FFF;
      TYPE_U32: top_mag = 64'hFFFF_FFFF;
      TYPE_I32: top_mag = 64'h7FFF_FFFF;
      TYPE_I64: top_mag = I64_MAG_MAX;
      default:  top_mag = '1;
    endcase
    if (type_has_sign(rtype)) begin
      if (acc > I64_MAG_MAX) return r;
      if (neg) begin
        if (acc > top_mag + 64'd1) return r;
        r.value = 64'd0 - acc;
        r.err   = 1'b0;
        return r;
      end
    end
    if (acc > top_mag) return r;
    r.value = acc;
    r.err   = 1'b0;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    parse_result_t due;
    if (rst) begin
      clear_string();
      rtype = TYPE_U64;
      results_due.delete();
    end else begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $error("result with no string pending: value %h parse_error %b",
                 value, parse_error);
          fails++;
        end else begin
          due = results_due.pop_front();
          if (value !== due.value) begin
            $error("value: expected %h, got %h", due.value, value);
            fails++;
          end
          if (parse_error !== due.err) begin
            $error("parse_error: expected %b, got %b", due.err, parse_error);
            fails++;
          end
        end
      end
      if (cfg_valid && cfg_ready) rtype = cfg_data;
      if (push && !full) begin
        // a zero character or anything after an error leaves the state alone
        if (ch != 8'h00 && !bad) take_char(ch);
        if (last) begin
          results_due.push_back(finish_string());
          clear_string();
        end
      end
    end
    fail_count   <= fails;
    results_owed <= results_due.size();
  end

endmodule

>>> dv/ascii_integer_parser_unit_test.sv
// ----------------------------------------------------------------------------
// ascii_integer_parser_unit_test
// Feeds the parser short directed strings and then random numeric strings
// (decimal and hex, signs, whitespace, range edges, corrupted and junk
// strings) under every result type, with random gaps on both queues.
// ----------------------------------------------------------------------------
module ascii_integer_parser_unit_test import aip_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] TYPE_RSVD6 = 3'd6;
  localparam logic [2:0] TYPE_RSVD7 = 3'd7;
  localparam int CYCLE_LIMIT = 300000;
  localparam int STAGE_CHARS = 267;
  localparam int TYPE_CHARS  = 35;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        push      = 1'b0;
  logic [7:0]  ch        = '0;
  logic        last      = 1'b0;
  logic        pop       = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [2:0]  cfg_data  = '0;
  logic        full;
  logic        empty;
  logic [63:0] value;
  logic        parse_error;
  logic        cfg_ready;

  int fail_count;
  int results_owed;
  int tx_idle     = 28;
  int rx_idle     = 63;
  int chars_sent  = 0;
  int cycle_count = 0;

  logic [2:0] cur_type = TYPE_U64;
  logic [7:0] text[$];

  ascii_integer_parser_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .ch          (ch),
    .last        (last),
    .empty       (empty),
    .pop         (pop),
    .value       (value),
    .parse_error (parse_error),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  ascii_integer_parser_checker parse_check (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .ch           (ch),
    .last         (last),
    .empty        (empty),
    .pop          (pop),
    .value        (value),
    .parse_error  (parse_error),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= ($urandom_range(0, 99) >= rx_idle);
  end

  task automatic send_byte(input logic [7:0] c, input logic l);
    while ($urandom_range(0, 99) < tx_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    ch   <= c;
    last <= l;
    @(posedge clk);
    while (full) @(posedge clk);
    if (c != 8'h00) chars_sent++;
  endtask

  task automatic send_text(input logic sprinkle);
    logic zero_end;
    zero_end = (text.size() == 0) || (sprinkle && $urandom_range(0, 19) == 0);
    foreach (text[i]) begin
      if (sprinkle && $urandom_range(0, 24) == 0) send_byte(8'h00, 1'b0);
      send_byte(text[i], !zero_end && i == text.size() - 1);
    end
    if (zero_end) send_byte(8'h00, 1'b1);
  endtask

  // type changes only once the parser has drained
  task automatic set_type(input logic [2:0] t);
    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= t;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cur_type = t;
  endtask

  task automatic add_ws(input int n);
    int k;
    repeat (n) begin
      k = $urandom_range(0, 5);
      text.push_back(k == 5 ? 8'h20 : 8'(9 + k));
    end
  endtask

  task automatic add_decimal(input logic [63:0] v, input int pad);
    logic [7:0] digits[$];
    repeat (pad) text.push_back("0");
    do begin
      digits.push_front(8'h30 + 8'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digits[i]) text.push_back(digits[i]);
  endtask

  task automatic add_hex(input logic [63:0] v, input int pad);
    logic [3:0] nib;
    logic [7:0] c;
    logic       started;
    text.push_back("0");
    text.push_back("x");
    repeat (pad) text.push_back("0");
    // bare prefix reads as zero
    if (v == 0 && $urandom_range(0, 1) == 0) return;
    started = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      nib = v[i*4 +: 4];
      if (nib != 0 || started || i == 0) begin
        started = 1'b1;
        if ($urandom_range(0, 6) == 0) text.push_back("_");
        if (nib < 4'd10) c = 8'h30 + 8'(nib);
        else c = ($urandom_range(0, 1) != 0 ? "a" : "A") + 8'(nib) - 8'd10;
        text.push_back(c);
      end
    end
  endtask

  function automatic logic [63:0] range_edge(input int k);
    case (k)
      0:  return 64'h7FFF;
      1:  return 64'h8000;
      2:  return 64'h8001;
      3:  return 64'hFFFF;
      4:  return 64'h1_0000;
      5:  return 64'h7FFF_FFFF;
      6:  return 64'h8000_0000;
      7:  return 64'h8000_0001;
      8:  return 64'hFFFF_FFFF;
      9:  return 64'h1_0000_0000;
      10: return 64'h7FFF_FFFF_FFFF_FFFF;
      11: return 64'h8000_0000_0000_0000;
      12: return 64'h8000_0000_0000_0001;
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  task automatic build_number();
    logic [63:0] mag;
    logic        with_sign;
    int          pad;
    int          form;
    if ($urandom_range(0, 1) == 0) add_ws($urandom_range(1, 2));
    if (is_signed_type(cur_type)) with_sign = ($urandom_range(0, 9) < 6);
    else with_sign = ($urandom_range(0, 19) == 0);
    if (with_sign) begin
      text.push_back($urandom_range(0, 2) == 0 ? "+" : "-");
      if ($urandom_range(0, 3) == 0) add_ws($urandom_range(1, 2));
    end
    case ($urandom_range(0, 3))
      0: mag = 64'($urandom_range(0, 999));
      1: mag = range_edge($urandom_range(0, 13));
      2: mag = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: mag = {$urandom, $urandom};
    endcase
    pad  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    form = $urandom_range(0, 9);
    if (form < 5) begin
      add_decimal(mag, pad);
    end else if (form < 9) begin
      add_hex(mag, pad);
    end else if ($urandom_range(0, 1) == 0) begin
      // decimal right at the 64-bit ceiling, sometimes past it
      add_decimal(DEC_LIMIT, 0);
      text.push_back(8'h30 + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 3) == 0) text.push_back("0");
    end else begin
      // a random hex value with one more digit appended, up to seventeen hex digits
      add_hex({$urandom, $urandom}, 0);
      text.push_back("7");
    end
    if ($urandom_range(0, 1) == 0) add_ws($urandom_range(1, 2));
  endtask

  task automatic make_string();
    int pick;
    int k;
    pick = $urandom_range(0, 19);
    text.delete();
    if (pick < 15) begin
      build_number();
    end else if (pick < 17) begin
      build_number();
      k = $urandom_range(0, text.size() - 1);
      if ($urandom_range(0, 1) == 0) text[k] = 8'($urandom_range(0, 255));
      else text.insert(k, 8'($urandom_range(8'h20, 8'h7E)));
    end else if (pick < 19) begin
      repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_ws($urandom_range(0, 2));
      if ($urandom_range(0, 1) == 0) text.push_back("-");
    end
  endtask

  initial begin
    int stage_end;
    int type_end;
    int type_step;
    logic [2:0] type_base;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty string made of a zero character alone
    text.delete();
    send_text(1'b0);
    text = '{"+", "5"};
    send_text(1'b0);
    text = '{"0", "x"};
    send_text(1'b0);
    text = '{8'hFF};
    send_text(1'b0);
    // zero character inside, then junk followed by a digit
    text = '{"1", 8'h00, "q", "2"};
    send_text(1'b0);
    set_type(TYPE_RSVD7);
    text = '{"9", " "};
    send_text(1'b0);
    set_type(TYPE_RSVD6);
    text = '{8'h0D, "3"};
    send_text(1'b0);
    set_type(TYPE_I16);
    text = '{"-", 8'h09, "0"};
    send_text(1'b0);
    text = '{"-"};
    send_text(1'b0);
    set_type(TYPE_U16);
    text = '{"0", "x", "A", "_", "f"};
    send_text(1'b0);

    type_base = 3'($urandom_range(0, 7));
    type_step = 0;
    for (int stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin tx_idle = 28; rx_idle = 63; end
        1: begin tx_idle = 63; rx_idle = 28; end
        default: begin tx_idle = 0; rx_idle = 0; end
      endcase
      stage_end = chars_sent + STAGE_CHARS;
      while (chars_sent < stage_end) begin
        set_type(type_base + 3'(type_step));
        type_step++;
        type_end = chars_sent + TYPE_CHARS;
        while (chars_sent < type_end) begin
          make_string();
          send_text(1'b1);
        end
      end
    end

    push <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
